[hw/rtl/mbpl_pkg.sv]
`default_nettype none

package mbpl_pkg;

    // field widths
    localparam int unsigned POS_W       = 17;
    localparam int unsigned MASK_W      = 16;
    localparam int unsigned BL_W        = 5;
    localparam int unsigned SCNT_CFG_W  = 13;
    localparam int unsigned CFG_DATA_W  = 13;
    localparam int unsigned CFG_IDX_W   = 1;
    localparam int unsigned REM_W       = 8;
    localparam int unsigned LINE_W      = 4;

    // divider chain lengths
    localparam int unsigned Q1_STEPS    = POS_W;
    localparam int unsigned Q2_STEPS    = 4;

    // layout constants
    localparam int unsigned LINES_MIN       = 3;
    localparam int unsigned LINES_MAX       = 16;
    localparam int unsigned LOW_POSITIONS   = 48;
    localparam int unsigned CYCLE_SAMPLES   = 16;
    localparam int unsigned MAX_SAMPLES_DEF = 4096;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BIT_LINES    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COUNT = 1'd1;

    typedef enum logic [1:0] {
        KIND_INVALID,
        KIND_LOW,
        KIND_UPPER,
        KIND_CYCLE
    } mbpl_kind_t;

    // one item in flight along the divider chain
    typedef struct packed {
        mbpl_kind_t         kind;
        logic [REM_W-1:0]   rem;   // partial remainder
        logic [POS_W-1:0]   dvd;   // dividend bits out at the top, quotient bits in at the bottom
        logic [REM_W-1:0]   div;   // divisor
        logic [POS_W-1:0]   quo;   // first quotient, held for the second pass
        logic [REM_W-1:0]   aux;   // first remainder, held for the second pass
    } mbpl_item_t;

endpackage

`default_nettype wire

[hw/rtl/metadata_bit_position_locator_core.sv]
`default_nettype none
// Channel  Direction  Handshake          Payload
// s_       in         s_valid/s_ready    s_position
// m_       out        m_valid/m_ready    m_sample_offset, m_bit_mask, m_found
// cfg_     in         cfg_wr_en          cfg_index, cfg_wr_data
//
// One position is taken per cycle while the output is not stalled; each result
// passes through one classify stage, a 17-cell divider chain, one realign stage,
// a 4-cell divider chain and the output register.
// aresetn is synchronous; it empties the pipe and restores bit_lines to 16
// and the frame length to MAX_SAMPLES.
// A stalled result holds the whole chain; s_ready follows m_ready then.

module metadata_bit_position_locator_core #(
    parameter int unsigned MAX_SAMPLES = mbpl_pkg::MAX_SAMPLES_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,

    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic [mbpl_pkg::POS_W-1:0]       s_position,

    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic [mbpl_pkg::POS_W-1:0]            m_sample_offset,
    output logic [mbpl_pkg::MASK_W-1:0]           m_bit_mask,
    output logic                                  m_found,

    input  wire logic                             cfg_wr_en,
    input  wire logic [mbpl_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [mbpl_pkg::CFG_DATA_W-1:0]  cfg_wr_data
);
    import mbpl_pkg::*;

    localparam int unsigned SC_NEED = $clog2(MAX_SAMPLES + 1);
    localparam int unsigned SC_W    = (SC_NEED > SCNT_CFG_W) ? SC_NEED : SCNT_CFG_W;

    logic [BL_W-1:0]    bit_lines_reg;
    logic [SC_W-1:0]    frame_len_reg;
    logic               advance;

    mbpl_item_t         item1 [0:Q1_STEPS];
    logic               valid1 [0:Q1_STEPS];
    mbpl_item_t         item2 [0:Q2_STEPS];
    logic               valid2 [0:Q2_STEPS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bit_lines_reg <= BL_W'(LINES_MAX);
            frame_len_reg <= SC_W'(MAX_SAMPLES);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_BIT_LINES:    bit_lines_reg <= cfg_wr_data[BL_W-1:0];
                REG_SAMPLE_COUNT: frame_len_reg <= SC_W'(cfg_wr_data[SCNT_CFG_W-1:0]);
                default: ;
            endcase
        end
    end

    // whole chain moves together unless the output holds an untaken result
    assign advance = !m_valid || m_ready;
    assign s_ready = advance;

    mbpl_pre u_pre (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .en            (advance),
        .in_valid      (s_valid),
        .position      (s_position),
        .bit_lines     (bit_lines_reg),
        .out_valid_reg (valid1[0]),
        .out_item_reg  (item1[0])
    );

    for (genvar i = 0; i < Q1_STEPS; i++) begin : g_div1
        mbpl_cell u_cell (
            .aclk          (aclk),
            .aresetn       (aresetn),
            .en            (advance),
            .in_valid      (valid1[i]),
            .in_item       (item1[i]),
            .out_valid_reg (valid1[i+1]),
            .out_item_reg  (item1[i+1])
        );
    end

    mbpl_mid u_mid (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .en            (advance),
        .bit_lines     (bit_lines_reg),
        .in_valid      (valid1[Q1_STEPS]),
        .in_item       (item1[Q1_STEPS]),
        .out_valid_reg (valid2[0]),
        .out_item_reg  (item2[0])
    );

    for (genvar j = 0; j < Q2_STEPS; j++) begin : g_div2
        mbpl_cell u_cell (
            .aclk          (aclk),
            .aresetn       (aresetn),
            .en            (advance),
            .in_valid      (valid2[j]),
            .in_item       (item2[j]),
            .out_valid_reg (valid2[j+1]),
            .out_item_reg  (item2[j+1])
        );
    end

    mbpl_post #(
        .SC_W (SC_W)
    ) u_post (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .en                (advance),
        .bit_lines         (bit_lines_reg),
        .frame_len         (frame_len_reg),
        .in_valid          (valid2[Q2_STEPS]),
        .in_item           (item2[Q2_STEPS]),
        .out_valid_reg     (m_valid),
        .sample_offset_reg (m_sample_offset),
        .bit_mask_reg      (m_bit_mask),
        .found_reg         (m_found)
    );

endmodule

`default_nettype wire

[hw/rtl/mbpl_pre.sv]
`default_nettype none

module mbpl_pre (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         en,
    input  wire logic                         in_valid,
    input  wire logic [mbpl_pkg::POS_W-1:0]   position,
    input  wire logic [mbpl_pkg::BL_W-1:0]    bit_lines,
    output logic                              out_valid_reg,
    output mbpl_pkg::mbpl_item_t              out_item_reg
);
    import mbpl_pkg::*;

    mbpl_item_t             item_next;
    logic [BL_W+3:0]        bl16;
    logic [POS_W-1:0]       upper_start;

    // 48 positions of the low lines plus 16*(bl-3) of the upper ones: 16*bl
    assign bl16        = {bit_lines, 4'b0000};
    assign upper_start = POS_W'(bl16);

    always_comb begin
        item_next      = '0;
        item_next.kind = KIND_INVALID;
        item_next.div  = REM_W'(CYCLE_SAMPLES);
        item_next.dvd  = position;
        if (!(bit_lines inside {[LINES_MIN:LINES_MAX]})) begin
            item_next.kind = KIND_INVALID;
        end else if (position < POS_W'(LOW_POSITIONS)) begin
            // sample in the low nibble, line in the quotient
            item_next.kind = KIND_LOW;
            item_next.div  = REM_W'(CYCLE_SAMPLES);
        end else if (position < upper_start) begin
            item_next.kind = KIND_UPPER;
            item_next.dvd  = position - POS_W'(LOW_POSITIONS);
            item_next.div  = REM_W'(bit_lines) - REM_W'(LINES_MIN);
        end else begin
            item_next.kind = KIND_CYCLE;
            item_next.dvd  = position - upper_start;
            item_next.div  = REM_W'(bl16 - 1'b1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_item_reg <= item_next;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/mbpl_cell.sv]
`default_nettype none

module mbpl_cell (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           en,
    input  wire logic           in_valid,
    input  wire mbpl_pkg::mbpl_item_t in_item,
    output logic                out_valid_reg,
    output mbpl_pkg::mbpl_item_t out_item_reg
);
    import mbpl_pkg::*;

    mbpl_item_t         item_next;
    logic [REM_W:0]     trial;
    logic [REM_W:0]     diff;
    logic               take;

    // one restoring step: bring down the next dividend bit, subtract if it fits
    assign trial = {in_item.rem, in_item.dvd[POS_W-1]};
    assign diff  = trial - {1'b0, in_item.div};
    assign take  = (trial >= {1'b0, in_item.div});

    always_comb begin
        item_next     = in_item;
        item_next.rem = take ? diff[REM_W-1:0] : trial[REM_W-1:0];
        item_next.dvd = {in_item.dvd[POS_W-2:0], take};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_item_reg <= item_next;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/mbpl_mid.sv]
`default_nettype none

module mbpl_mid (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         en,
    input  wire logic [mbpl_pkg::BL_W-1:0]    bit_lines,
    input  wire logic                         in_valid,
    input  wire mbpl_pkg::mbpl_item_t         in_item,
    output logic                              out_valid_reg,
    output mbpl_pkg::mbpl_item_t              out_item_reg
);
    import mbpl_pkg::*;

    mbpl_item_t         item_next;
    logic [REM_W-1:0]   within_p1;

    // within+1 folds the reserved line 0 of the cycle's first sample into
    // a plain division by bit_lines; quotient stays below 16
    assign within_p1 = in_item.rem + 1'b1;

    always_comb begin
        item_next      = in_item;
        item_next.quo  = in_item.dvd;
        item_next.aux  = in_item.rem;
        item_next.rem  = REM_W'(within_p1[REM_W-1:Q2_STEPS]);
        item_next.dvd  = {within_p1[Q2_STEPS-1:0], (POS_W-Q2_STEPS)'(0)};
        item_next.div  = REM_W'(bit_lines);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_item_reg <= item_next;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/mbpl_post.sv]
`default_nettype none

module mbpl_post #(
    parameter int unsigned SC_W = mbpl_pkg::SCNT_CFG_W
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         en,
    input  wire logic [mbpl_pkg::BL_W-1:0]    bit_lines,
    input  wire logic [SC_W-1:0]              frame_len,
    input  wire logic                         in_valid,
    input  wire mbpl_pkg::mbpl_item_t         in_item,
    output logic                              out_valid_reg,
    output logic [mbpl_pkg::POS_W-1:0]        sample_offset_reg,
    output logic [mbpl_pkg::MASK_W-1:0]       bit_mask_reg,
    output logic                              found_reg
);
    import mbpl_pkg::*;

    localparam int unsigned CMP_W = (SC_W > POS_W) ? SC_W : POS_W;

    logic [POS_W-1:0]       offset;
    logic [BL_W-1:0]        line;
    logic [POS_W-1:0]       cycle_first;
    logic [Q2_STEPS-1:0]    q2;
    logic [POS_W-1:0]       sample_offset_next;
    logic [MASK_W-1:0]      bit_mask_next;
    logic                   found_next;

    assign q2          = in_item.dvd[Q2_STEPS-1:0];
    assign cycle_first = {in_item.quo[POS_W-5:0], 4'b0000} + POS_W'(CYCLE_SAMPLES);

    always_comb begin
        offset = '0;
        line   = '0;
        case (in_item.kind)
            KIND_LOW: begin
                offset = POS_W'(in_item.aux);
                line   = BL_W'(in_item.quo[1:0]);
            end
            KIND_UPPER: begin
                offset = in_item.quo;
                line   = bit_lines - 1'b1 - BL_W'(in_item.aux);
            end
            KIND_CYCLE: begin
                offset = cycle_first + POS_W'(q2);
                // first sample of the cycle skips line 0
                line   = bit_lines - 1'b1 - BL_W'(in_item.rem)
                         + BL_W'(q2 == '0);
            end
            default: begin
                offset = '0;
                line   = '0;
            end
        endcase
    end

    always_comb begin
        if (in_item.kind == KIND_INVALID) begin
            sample_offset_next = '0;
            bit_mask_next      = '0;
            found_next         = 1'b0;
        end else begin
            sample_offset_next = offset;
            bit_mask_next      = MASK_W'(1) << line[LINE_W-1:0];
            found_next         = (CMP_W'(offset) < CMP_W'(frame_len));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sample_offset_reg <= sample_offset_next;
            bit_mask_reg      <= bit_mask_next;
            found_reg         <= found_next;
        end
    end

endmodule

`default_nettype wire
